@@ hw/rtl/bpfe_pkg.sv @@
// Shared types and constants of the BMP pixel format expander.
`timescale 1ns / 1ps
`default_nettype none

package bpfe_pkg;

  localparam int DEF_MAX_WIDTH     = 4096;
  localparam int DEF_MAX_HEIGHT    = 4096;
  localparam int DEF_PALETTE_DEPTH = 256;

  localparam int DIM_W = 13;
  localparam int BIR_W = 16;

  localparam logic CMD_PIXEL   = 1'b0;
  localparam logic CMD_PALETTE = 1'b1;

  typedef enum logic [2:0] {
    MODE_1BPP = 3'd0,
    MODE_4BPP = 3'd1,
    MODE_8BPP = 3'd2,
    MODE_555  = 3'd3,
    MODE_565  = 3'd4,
    MODE_24   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    REG_PIXEL_MODE   = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_BLUE_MASK    = 3'd3,
    REG_GREEN_MASK   = 3'd4,
    REG_RED_MASK     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    mode_t             mode;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [15:0]       blue_mask;
    logic [15:0]       green_mask;
    logic [15:0]       red_mask;
  } cfg_t;

  typedef struct packed {
    logic        is_write;
    mode_t       mode;
    logic [31:0] data;
    logic [7:0]  windex;
    logic [3:0]  count;
    logic        eor;
    logic        eoi;
  } job_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       end_of_row;
    logic       end_of_image;
    logic       last;
  } pix_t;

  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } buf_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/bpfe_palette_ram.sv @@
// Palette memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bpfe_palette_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bpfe_front.sv @@
// Input stage: position counters, byte assembly and job generation.
`timescale 1ns / 1ps
`default_nettype none

module bpfe_front import bpfe_pkg::*; #(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       cmd,
  input  wire logic       first_byte,
  input  wire logic [7:0] source_byte,
  input  wire logic [7:0] palette_index,
  input  wire logic [31:0] palette_entry,
  output logic            job_valid,
  output job_t            job,
  input  wire logic       job_pop
);

  logic [DIM_W-1:0] column, column_next, col_e;
  logic [DIM_W-1:0] row, row_next, row_e;
  logic [BIR_W-1:0] byte_in_row, byte_in_row_next, bir_e;
  logic [15:0]      held_bytes, held_bytes_next, held_e;
  logic [1:0]       byte_phase, byte_phase_next, phase_e;
  logic             job_valid_next;
  job_t             job_next;

  logic             accept, mode_ok, col_ok, row_end, eor, eoi, pal_ok;
  logic [DIM_W-1:0] w, h;
  logic [DIM_W:0]   diff, col_sum;
  logic [3:0]       n;
  logic [15:0]      word;
  logic [23:0]      bgr;
  logic [17:0]      bits;
  logic [18:0]      bits_sum;
  logic [BIR_W-1:0] rowlen, bir_inc;

  assign in_ready = !job_valid || job_pop;
  assign accept   = in_valid && in_ready;
  assign pal_ok   = {24'd0, palette_index} < 32'(PALETTE_DEPTH);

  always_comb begin
    if (cfg.width == '0) begin
      w = DIM_W'(1);
    end else if ({19'd0, cfg.width} > 32'(MAX_WIDTH)) begin
      w = DIM_W'(MAX_WIDTH);
    end else begin
      w = cfg.width;
    end
    if (cfg.height == '0) begin
      h = DIM_W'(1);
    end else if ({19'd0, cfg.height} > 32'(MAX_HEIGHT)) begin
      h = DIM_W'(MAX_HEIGHT);
    end else begin
      h = cfg.height;
    end
  end

  always_comb begin
    case (cfg.mode)
      MODE_1BPP:           bits = {5'd0, w};
      MODE_4BPP:           bits = {3'd0, w, 2'b00};
      MODE_8BPP:           bits = {2'd0, w, 3'b000};
      MODE_555, MODE_565:  bits = {1'b0, w, 4'b0000};
      default:             bits = {1'b0, w, 4'b0000} + {2'd0, w, 3'b000};
    endcase
    bits_sum = {1'b0, bits} + 19'd31;
    rowlen   = {bits_sum[18:5], 2'b00};
  end

  always_comb begin
    col_e   = first_byte ? '0 : column;
    row_e   = first_byte ? '0 : row;
    bir_e   = first_byte ? '0 : byte_in_row;
    held_e  = first_byte ? '0 : held_bytes;
    phase_e = first_byte ? '0 : byte_phase;

    col_ok  = col_e < w;
    diff    = {1'b0, w} - {1'b0, col_e};
    word    = {source_byte, held_e[7:0]};
    n       = '0;
    bgr     = '0;
    mode_ok = 1'b1;
    held_bytes_next = held_e;
    byte_phase_next = phase_e;

    case (cfg.mode)
      MODE_1BPP: begin
        if (col_ok) begin
          n = (diff >= 14'd8) ? 4'd8 : diff[3:0];
        end
      end
      MODE_4BPP: begin
        if (col_ok) begin
          n = (diff >= 14'd2) ? 4'd2 : diff[3:0];
        end
      end
      MODE_8BPP: begin
        if (col_ok) begin
          n = 4'd1;
        end
      end
      MODE_555: begin
        if (col_ok) begin
          if (phase_e == 2'd0) begin
            held_bytes_next = {8'd0, source_byte};
            byte_phase_next = 2'd1;
          end else begin
            n = 4'd1;
            held_bytes_next = '0;
            byte_phase_next = 2'd0;
            bgr = {word[14:10], 3'b000, word[9:5], 3'b000, word[4:0], 3'b000};
          end
        end
      end
      MODE_565: begin
        if (col_ok) begin
          if (phase_e == 2'd0) begin
            held_bytes_next = {8'd0, source_byte};
            byte_phase_next = 2'd1;
          end else begin
            n = 4'd1;
            held_bytes_next = '0;
            byte_phase_next = 2'd0;
            bgr = {(word[15:11] & cfg.red_mask[15:11]), 3'b000,
                   (word[10:5] & cfg.green_mask[10:5]), 2'b00,
                   (word[4:0] & cfg.blue_mask[4:0]), 3'b000};
          end
        end
      end
      MODE_24: begin
        if (col_ok) begin
          if (phase_e == 2'd0) begin
            held_bytes_next = {8'd0, source_byte};
            byte_phase_next = 2'd1;
          end else if (phase_e == 2'd1) begin
            held_bytes_next = {source_byte, held_e[7:0]};
            byte_phase_next = 2'd2;
          end else begin
            n = 4'd1;
            held_bytes_next = '0;
            byte_phase_next = 2'd0;
            bgr = {source_byte, held_e[15:8], held_e[7:0]};
          end
        end
      end
      default: begin
        mode_ok = 1'b0;
      end
    endcase

    col_sum = {1'b0, col_e} + {{(DIM_W-3){1'b0}}, n};
    eor     = (n != 4'd0) && (col_sum == {1'b0, w});
    eoi     = eor && (row_e == (h - DIM_W'(1)));
    bir_inc = bir_e + BIR_W'(1);
    row_end = bir_inc >= rowlen;

    column_next      = col_sum[DIM_W-1:0];
    row_next         = row_e;
    byte_in_row_next = bir_inc;
    if (row_end) begin
      column_next      = '0;
      byte_in_row_next = '0;
      held_bytes_next  = '0;
      byte_phase_next  = '0;
      row_next         = (row_e + DIM_W'(1) >= h) ? '0 : row_e + DIM_W'(1);
    end
    if (!mode_ok) begin
      column_next      = col_e;
      row_next         = row_e;
      byte_in_row_next = bir_e;
      held_bytes_next  = held_e;
      byte_phase_next  = phase_e;
    end
  end

  always_comb begin
    job_next         = job;
    job_next.is_write = (cmd == CMD_PALETTE);
    job_next.mode    = cfg.mode;
    job_next.windex  = palette_index;
    job_next.count   = n;
    job_next.eor     = eor;
    job_next.eoi     = eoi;
    case (cfg.mode)
      MODE_1BPP, MODE_4BPP, MODE_8BPP: job_next.data = {24'd0, source_byte};
      default:                         job_next.data = {8'd0, bgr};
    endcase
    if (cmd == CMD_PALETTE) begin
      job_next.data  = palette_entry;
      job_next.count = '0;
    end

    job_valid_next = job_valid && !job_pop;
    if (accept) begin
      if (cmd == CMD_PALETTE) begin
        job_valid_next = pal_ok;
      end else begin
        job_valid_next = mode_ok && (n != 4'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      row         <= '0;
      byte_in_row <= '0;
      held_bytes  <= '0;
      byte_phase  <= '0;
      job_valid   <= 1'b0;
    end else begin
      job_valid <= job_valid_next;
      if (accept && cmd == CMD_PIXEL) begin
        column      <= column_next;
        row         <= row_next;
        byte_in_row <= byte_in_row_next;
        held_bytes  <= held_bytes_next;
        byte_phase  <= byte_phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bpfe_seq.sv @@
// Palette sequencer: one access per cycle unless held; data to pixel.
`timescale 1ns / 1ps
`default_nettype none

module bpfe_seq import bpfe_pkg::*; #(
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
  parameter int AW            = $clog2(PALETTE_DEPTH)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        job_valid,
  input  wire job_t        job,
  output logic             job_pop,
  input  wire buf_stat_t   stat,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic [31:0]      ram_wdata,
  output logic             ram_re,
  output logic [AW-1:0]    ram_raddr,
  input  wire logic [31:0] ram_rdata,
  output logic             push,
  output pix_t             pix
);

  logic [2:0]  k, k_next;
  logic        s1_valid;
  logic        s1_pal, s1_alpha, s1_oor, s1_eor, s1_eoi, s1_last;
  logic [23:0] s1_bgr;

  logic        credit_ok, is_last, issue;
  logic [7:0]  idx;
  logic [31:0] e;

  assign credit_ok = ({1'b0, stat.count} + {2'b00, s1_valid}) <= (3'd1 + {2'b00, stat.pop});
  assign is_last   = ({1'b0, k} + 4'd1) == job.count;
  assign issue     = job_valid && !job.is_write && credit_ok;

  always_comb begin
    case (job.mode)
      MODE_1BPP: idx = {7'd0, job.data[3'd7 - k]};
      MODE_4BPP: idx = (k == 3'd0) ? {4'd0, job.data[7:4]} : {4'd0, job.data[3:0]};
      default:   idx = job.data[7:0];
    endcase
  end

  always_comb begin
    ram_we    = job_valid && job.is_write;
    ram_waddr = job.windex[AW-1:0];
    ram_wdata = job.data;
    ram_re    = issue;
    ram_raddr = idx[AW-1:0];
    job_pop   = ram_we || (issue && is_last);
    k_next    = k;
    if (issue) begin
      k_next = is_last ? 3'd0 : k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      s1_valid <= 1'b0;
    end else begin
      k        <= k_next;
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_pal   <= (job.mode == MODE_1BPP) || (job.mode == MODE_4BPP) ||
                  (job.mode == MODE_8BPP);
      s1_alpha <= job.mode == MODE_8BPP;
      s1_oor   <= {24'd0, idx} >= 32'(PALETTE_DEPTH);
      s1_bgr   <= job.data[23:0];
      s1_eor   <= job.eor && is_last;
      s1_eoi   <= job.eoi && is_last;
      s1_last  <= is_last;
    end
  end

  assign push = s1_valid;
  assign e    = s1_oor ? '0 : ram_rdata;

  always_comb begin
    if (s1_pal) begin
      pix.blue  = e[7:0];
      pix.green = e[15:8];
      pix.red   = e[23:16];
      pix.alpha = s1_alpha ? e[31:24] : 8'd0;
    end else begin
      pix.blue  = s1_bgr[7:0];
      pix.green = s1_bgr[15:8];
      pix.red   = s1_bgr[23:16];
      pix.alpha = 8'd0;
    end
    pix.end_of_row   = s1_eor;
    pix.end_of_image = s1_eoi;
    pix.last         = s1_last;
  end

endmodule

`default_nettype wire

@@ hw/rtl/bpfe_out_buf.sv @@
// Two-entry output buffer that absorbs the palette read latency.
`timescale 1ns / 1ps
`default_nettype none

module bpfe_out_buf import bpfe_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire pix_t  pix_in,
  output logic       out_valid,
  input  wire logic  out_ready,
  output pix_t       head,
  output buf_stat_t  stat
);

  pix_t       entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid  = count != 2'd0;
  assign pop        = out_valid && out_ready;
  assign head       = entry[rd_ptr];
  assign stat.count = count;
  assign stat.pop   = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= pix_in;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bmp_pixel_format_expander_unit.sv @@
// Top level of the BMP pixel format expander.
`timescale 1ns / 1ps
`default_nettype none

// Unpacks row-padded bottom-up BMP pixel bytes into blue/green/red/alpha
// beats. One input beat is taken per cycle in the 8, 16 and 24 bit modes,
// for padding bytes and for palette writes, unless the output is held; a
// 4bpp byte needs up to 2 palette lookups and a 1bpp byte up to 8, since the
// sequencer makes one palette lookup or write at a time and one pixel leaves
// per cycle. A byte's first pixel passes the job register, the read stage
// and the output buffer. Palette entries read before being written return
// undefined data; there is no clearing pass after reset.
// Configuration writes are always taken and must only be issued while the
// block is idle.

module bmp_pixel_format_expander_unit import bpfe_pkg::*; #(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic        first_byte,
  input  wire logic [7:0]  source_byte,
  input  wire logic [7:0]  palette_index,
  input  wire logic [31:0] palette_entry,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       blue,
  output logic [7:0]       green,
  output logic [7:0]       red,
  output logic [7:0]       alpha,
  output logic             end_of_row,
  output logic             end_of_image,
  output logic             last
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  cfg_t        cfg;
  logic        job_valid, job_pop;
  job_t        job;
  buf_stat_t   stat;
  logic        ram_we, ram_re, push;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;
  pix_t        pix, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= MODE_8BPP;
      cfg.width       <= DIM_W'(640);
      cfg.height      <= DIM_W'(480);
      cfg.blue_mask   <= 16'h001F;
      cfg.green_mask  <= 16'h07E0;
      cfg.red_mask    <= 16'hF800;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PIXEL_MODE:   cfg.mode       <= mode_t'(cfg_data[2:0]);
        REG_IMAGE_WIDTH:  cfg.width      <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.height     <= cfg_data[DIM_W-1:0];
        REG_BLUE_MASK:    cfg.blue_mask  <= cfg_data;
        REG_GREEN_MASK:   cfg.green_mask <= cfg_data;
        REG_RED_MASK:     cfg.red_mask   <= cfg_data;
        default: ;
      endcase
    end
  end

  bpfe_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .first_byte    (first_byte),
    .source_byte   (source_byte),
    .palette_index (palette_index),
    .palette_entry (palette_entry),
    .job_valid     (job_valid),
    .job           (job),
    .job_pop       (job_pop)
  );

  bpfe_seq #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .AW            (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .stat      (stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .push      (push),
    .pix       (pix)
  );

  bpfe_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpfe_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pix_in    (pix),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .stat      (stat)
  );

  assign blue         = head.blue;
  assign green        = head.green;
  assign red          = head.red;
  assign alpha        = head.alpha;
  assign end_of_row   = head.end_of_row;
  assign end_of_image = head.end_of_image;
  assign last         = head.last;

endmodule

`default_nettype wire
